// ===== rtl/core/u8vr_pkg.sv =====
package u8vr_pkg;

    // replacement character U+FFFD
    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    // continuation byte pattern
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    // default continuation range
    localparam logic [7:0] CONT_LO = 8'h80;
    localparam logic [7:0] CONT_HI = 8'hBF;

    // lead byte boundaries
    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD_E0  = 8'hE0;
    localparam logic [7:0] LEAD_ED  = 8'hED;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD_F0  = 8'hF0;
    localparam logic [7:0] LEAD_F4  = 8'hF4;

    // narrowed first-continuation limits
    localparam logic [7:0] E0_LO = 8'hA0;
    localparam logic [7:0] ED_HI = 8'h9F;
    localparam logic [7:0] F0_LO = 8'h90;
    localparam logic [7:0] F4_HI = 8'h8F;

    // sequence lengths
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    typedef struct packed {
        logic [2:0] len;
        logic [7:0] lo;
        logic [7:0] hi;
    } lead_t;

    // one emission job: rep_cnt replacement characters, then pass_cnt bytes
    typedef struct packed {
        logic [2:0]      rep_cnt;
        logic [2:0]      pass_cnt;
        logic [3:0][7:0] pass_bytes;
        logic            all_valid;
        logic            last;
    } cmd_t;

    // sequence length and first-continuation range of a lead byte
    function automatic lead_t lead_info(input logic [7:0] c);
        lead_t r;
        r.len = LEN_NONE;
        r.lo  = CONT_LO;
        r.hi  = CONT_HI;
        if (c >= LEAD2_LO && c <= LEAD2_HI) begin
            r.len = LEN_2;
        end else if (c == LEAD_E0) begin
            r.len = LEN_3;
            r.lo  = E0_LO;
        end else if (c == LEAD_ED) begin
            r.len = LEN_3;
            r.hi  = ED_HI;
        end else if (c > LEAD_E0 && c <= LEAD3_HI) begin
            r.len = LEN_3;
        end else if (c == LEAD_F0) begin
            r.len = LEN_4;
            r.lo  = F0_LO;
        end else if (c > LEAD_F0 && c < LEAD_F4) begin
            r.len = LEN_4;
        end else if (c == LEAD_F4) begin
            r.len = LEN_4;
            r.hi  = F4_HI;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/u8vr_front.sv =====
module u8vr_front
    import u8vr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       q_full,
    output logic       push,
    output cmd_t       cmd
);

    logic [2:0][7:0] held_reg, held_next;
    logic [1:0]      hcnt_reg, hcnt_next;
    logic [2:0]      exp_reg, exp_next;
    logic            flag_reg, flag_next;

    lead_t lead_b;
    lead_t lead_h;
    logic  fits;
    logic  take;
    logic  accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // classify the byte against the pending sequence
    always_comb begin
        lead_b    = lead_info(s_tdata);
        lead_h    = lead_info(held_reg[0]);
        held_next = held_reg;
        hcnt_next = hcnt_reg;
        exp_next  = exp_reg;
        flag_next = flag_reg;
        take      = 1'b0;
        fits      = 1'b0;
        cmd       = '0;

        if (hcnt_reg == 2'd0) begin
            take = 1'b1;
        end else begin
            if (hcnt_reg == 2'd1) begin
                fits = (s_tdata >= lead_h.lo) && (s_tdata <= lead_h.hi);
            end else begin
                fits = (s_tdata & CONT_MASK) == CONT_TAG;
            end
            if (!fits) begin
                // broken sequence: replace every held byte
                cmd.rep_cnt = {1'b0, hcnt_reg};
                flag_next   = 1'b0;
                hcnt_next   = 2'd0;
                exp_next    = LEN_NONE;
                take        = 1'b1;
            end else if ({1'b0, hcnt_reg} + 3'd1 >= exp_reg) begin
                // complete sequence passes through
                cmd.pass_cnt = {1'b0, hcnt_reg} + 3'd1;
                for (int k = 0; k < 4; k++) begin
                    if (2'(k) < hcnt_reg && k < 3) begin
                        cmd.pass_bytes[k] = held_reg[k[1:0]];
                    end else begin
                        cmd.pass_bytes[k] = s_tdata;
                    end
                end
                hcnt_next = 2'd0;
                exp_next  = LEN_NONE;
            end else begin
                if (hcnt_reg != 2'd3) begin
                    held_next[hcnt_reg] = s_tdata;
                end
                hcnt_next = hcnt_reg + 2'd1;
            end
        end

        // decode as a new lead
        if (take) begin
            if (!s_tdata[7]) begin
                cmd.pass_cnt      = 3'd1;
                cmd.pass_bytes[0] = s_tdata;
            end else if (lead_b.len == LEN_NONE) begin
                cmd.rep_cnt = cmd.rep_cnt + 3'd1;
                flag_next   = 1'b0;
            end else begin
                held_next[0] = s_tdata;
                hcnt_next    = 2'd1;
                exp_next     = lead_b.len;
            end
        end

        // flush a truncated sequence at end of string
        if (s_tlast && hcnt_next != 2'd0) begin
            cmd.rep_cnt = cmd.rep_cnt + {1'b0, hcnt_next};
            flag_next   = 1'b0;
        end

        cmd.all_valid = flag_next;
        cmd.last      = s_tlast;

        if (s_tlast) begin
            hcnt_next = 2'd0;
            exp_next  = LEN_NONE;
            flag_next = 1'b1;
        end
    end

    assign push = accept && (cmd.rep_cnt != 3'd0 || cmd.pass_cnt != 3'd0);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hcnt_reg <= 2'd0;
            exp_reg  <= LEN_NONE;
            flag_reg <= 1'b1;
        end else if (accept) begin
            hcnt_reg <= hcnt_next;
            exp_reg  <= exp_next;
            flag_reg <= flag_next;
        end
    end

    // held bytes of a pending sequence
    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg <= held_next;
        end
    end

endmodule

// ===== rtl/core/u8vr_queue.sv =====
module u8vr_queue
    import u8vr_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full  = cnt_reg == CNT_FULL;
    assign empty = cnt_reg == '0;
    assign head  = mem[rptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/u8vr_back.sv =====
module u8vr_back
    import u8vr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       head,
    input  logic       q_empty,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    typedef enum logic [2:0] {
        PH_B0 = 3'b001,
        PH_B1 = 3'b010,
        PH_B2 = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [2:0] rep_done_reg, rep_done_next;
    logic [1:0] pass_idx_reg, pass_idx_next;

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg;
    logic       m_tuser_reg;

    logic q_valid;
    logic advance;
    logic in_rep;
    logic cmd_end;

    assign q_valid = !q_empty;
    assign advance = q_valid && (!m_tvalid_reg || m_tready);
    assign in_rep  = rep_done_reg < head.rep_cnt;
    assign pop     = advance && cmd_end;

    // select the next byte of the head job
    always_comb begin
        phase_next    = phase_reg;
        rep_done_next = rep_done_reg;
        pass_idx_next = pass_idx_reg;
        m_tdata_next  = head.pass_bytes[pass_idx_reg];
        cmd_end       = 1'b0;
        if (in_rep) begin
            unique case (phase_reg)
                PH_B0: begin
                    m_tdata_next = REPL_B0;
                    phase_next   = PH_B1;
                end
                PH_B1: begin
                    m_tdata_next = REPL_B1;
                    phase_next   = PH_B2;
                end
                PH_B2: begin
                    m_tdata_next  = REPL_B2;
                    phase_next    = PH_B0;
                    rep_done_next = rep_done_reg + 3'd1;
                    cmd_end       = (rep_done_reg + 3'd1 == head.rep_cnt) &&
                                    (head.pass_cnt == 3'd0);
                end
                default: begin
                    m_tdata_next = REPL_B0;
                    phase_next   = PH_B0;
                end
            endcase
        end else begin
            pass_idx_next = pass_idx_reg + 2'd1;
            cmd_end       = ({1'b0, pass_idx_reg} + 3'd1 == head.pass_cnt);
        end
        if (cmd_end) begin
            phase_next    = PH_B0;
            rep_done_next = 3'd0;
            pass_idx_next = 2'd0;
        end
    end

    // progress through the head job
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_B0;
            rep_done_reg <= 3'd0;
            pass_idx_reg <= 2'd0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            rep_done_reg <= rep_done_next;
            pass_idx_reg <= pass_idx_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= head.last && cmd_end;
            m_tuser_reg <= head.all_valid;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // replacement progress never passes the job's count
    a_rep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> rep_done_reg <= head.rep_cnt)
        else $error("replacement count overrun");

    // a job with replacements never claims a valid string
    a_rep_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && head.rep_cnt != 3'd0) |-> !head.all_valid)
        else $error("replacement job marked valid");

    // counters sit at their start whenever no job is waiting
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_valid |-> (rep_done_reg == 3'd0 && pass_idx_reg == 2'd0 &&
                      phase_reg == PH_B0))
        else $error("job counters not cleared between jobs");

endmodule

// ===== rtl/core/utf8_validate_and_repair.sv =====
// utf8_validate_and_repair
// s_ channel: one text byte per item in s_tdata, s_tlast on the final byte of
// the string. m_ channel: repaired bytes in m_tdata, m_tlast on the final
// output byte of the string, m_tuser high while the string is well formed so
// far (the value after the input item that caused the byte).
// a complete sequence passes through once its last byte arrives; a byte that
// breaks a sequence turns every held byte into EF BF BD and is decoded again.
// the front decoder takes one item per cycle while the queue has room and
// queues a job for each item that yields bytes (QUEUE_DEPTH entries); the back
// end emits that job's bytes, up to 12, one byte per cycle unless m_tready
// stalls it. an accepted item's job is written to the queue, then its first
// byte to the output register. throughput: one item per cycle while each yields
// at most one byte and m_tready is high; input stalls only once the queue fills.
// a stall on m_tready holds the output register; the queue keeps absorbing
// items until full, then s_tready drops.
// reset (aresetn low, synchronous) empties the queue, drops any pending
// sequence and sets the valid flag; after each final byte the same state
// returns for the next string.
module utf8_validate_and_repair
    import u8vr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,
    output logic       m_tuser    // text_valid
);

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic pop;
    cmd_t head;
    logic q_empty;

    // decode and classify
    u8vr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    // job queue
    u8vr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    // byte emission
    u8vr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import u8vr_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_in_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ok;
    } text_out_t;

    localparam int N_DIR = 26;
    localparam int N_ITEMS = 280;

    // directed strings: well-formed extremes, broken and stray bytes, truncated tail
    localparam logic [7:0] DIR_BYTES [N_DIR] = '{
        8'h01, 8'h7F, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
        8'hC2, 8'h41, 8'hE0, 8'h9F, 8'hED, 8'hA0, 8'hF0, 8'h8F, 8'hC1, 8'hF5, 8'hFF,
        8'hF3, 8'hBF, 8'hBF, 8'hF4
    };
    localparam logic [N_DIR-1:0] DIR_ENDS = N_DIR'((1 << 10) | (1 << 21) | (1 << 25));

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    text_in_t   tx_items[$];
    text_out_t  expected_out[$];
    text_out_t  step_out[$];
    logic [7:0] str_bytes[$];

    // predictor state: pending sequence and running validity of the string
    logic [7:0] pend_bytes [3];
    int         pend_cnt = 0;
    int         pend_len = 0;
    logic       text_ok = 1'b1;

    int errors = 0;
    int n_items = 0;
    int n_bytes = 0;
    int n_repl = 0;
    int n_strings = 0;
    int n_holds = 0;

    utf8_validate_and_repair u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // sequence length of a lead byte (0 if none) and range of its first continuation
    function automatic void seq_shape(input logic [7:0] c, output int len,
                                      output logic [7:0] lo, output logic [7:0] hi);
        lo  = CONT_LO;
        hi  = CONT_HI;
        len = 0;
        if (c >= LEAD2_LO && c <= LEAD2_HI) begin
            len = 2;
        end else if (c >= LEAD_E0 && c <= LEAD3_HI) begin
            len = 3;
            if (c == LEAD_E0) lo = E0_LO;
            if (c == LEAD_ED) hi = ED_HI;
        end else if (c >= LEAD_F0 && c <= LEAD_F4) begin
            len = 4;
            if (c == LEAD_F0) lo = F0_LO;
            if (c == LEAD_F4) hi = F4_HI;
        end
    endfunction

    task automatic emit_byte(input logic [7:0] b);
        text_out_t r;
        r.data = b;
        r.last = 1'b0;
        r.ok   = 1'b0;
        step_out.push_back(r);
    endtask

    task automatic emit_repl();
        emit_byte(REPL_B0);
        emit_byte(REPL_B1);
        emit_byte(REPL_B2);
        text_ok = 1'b0;
        n_repl++;
    endtask

    task automatic flush_pending();
        for (int k = 0; k < pend_cnt; k++) emit_repl();
        pend_cnt = 0;
        pend_len = 0;
    endtask

    task automatic take_lead(input logic [7:0] b);
        int         len;
        logic [7:0] lo, hi;
        seq_shape(b, len, lo, hi);
        if (b[7] == 1'b0) begin
            emit_byte(b);
        end else if (len == 0) begin
            emit_repl();
        end else begin
            pend_bytes[0] = b;
            pend_cnt = 1;
            pend_len = len;
        end
    endtask

    // expected output bytes for one accepted input item
    task automatic predict_item(input logic [7:0] b, input logic last);
        int         len;
        logic [7:0] lo, hi;
        logic       fits;
        step_out.delete();
        if (pend_cnt == 0) begin
            take_lead(b);
        end else begin
            if (pend_cnt == 1) begin
                seq_shape(pend_bytes[0], len, lo, hi);
                fits = (b >= lo && b <= hi);
            end else begin
                fits = ((b & CONT_MASK) == CONT_TAG);
            end
            if (!fits) begin
                flush_pending();
                take_lead(b);
            end else if (pend_cnt + 1 >= pend_len) begin
                for (int k = 0; k < pend_cnt; k++) emit_byte(pend_bytes[k]);
                emit_byte(b);
                pend_cnt = 0;
                pend_len = 0;
            end else begin
                pend_bytes[pend_cnt] = b;
                pend_cnt++;
            end
        end
        if (last) flush_pending();
        foreach (step_out[i]) step_out[i].ok = text_ok;
        if (last) begin
            step_out[step_out.size() - 1].last = 1'b1;
            text_ok = 1'b1;
            n_strings++;
        end
        foreach (step_out[i]) expected_out.push_back(step_out[i]);
    endtask

    // value in [lo, hi], with the bounds themselves favored
    function automatic logic [7:0] pick_in(input logic [7:0] lo, input logic [7:0] hi);
        int r;
        r = $urandom_range(0, 5);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return 8'($urandom_range(hi, lo));
    endfunction

    // one well-formed character of the given length
    task automatic add_good_char(input int len);
        int         n;
        logic [7:0] lead, lo, hi;
        case (len)
            1: lead = pick_in(8'h01, 8'h7F);
            2: lead = pick_in(LEAD2_LO, LEAD2_HI);
            3: lead = pick_in(LEAD_E0, LEAD3_HI);
            default: lead = pick_in(LEAD_F0, LEAD_F4);
        endcase
        str_bytes.push_back(lead);
        if (len > 1) begin
            seq_shape(lead, n, lo, hi);
            str_bytes.push_back(pick_in(lo, hi));
            for (int k = 2; k < len; k++) str_bytes.push_back(pick_in(CONT_LO, CONT_HI));
        end
    endtask

    // truncated sequence, often followed by a random byte that may break it
    task automatic add_broken_seq();
        int len;
        len = $urandom_range(2, 4);
        add_good_char(len);
        repeat ($urandom_range(1, len - 1)) void'(str_bytes.pop_back());
        if ($urandom_range(0, 1) == 1) str_bytes.push_back(8'($urandom_range(1, 255)));
    endtask

    task automatic close_string();
        text_in_t it;
        foreach (str_bytes[i]) begin
            it.data = str_bytes[i];
            it.last = (i == str_bytes.size() - 1);
            tx_items.push_back(it);
        end
        str_bytes.delete();
    endtask

    // driver: bursts of items with random gaps
    int       burst_left = 0;
    int       gap_left = 0;
    logic     drv_busy = 1'b0;
    text_in_t drv_item = '0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (drv_busy && s_tready) begin
                predict_item(drv_item.data, drv_item.last);
                n_items++;
                drv_busy = 1'b0;
            end
            if (!drv_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (tx_items.size() != 0) begin
                    drv_item = tx_items.pop_front();
                    drv_busy = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_tvalid <= drv_busy;
            s_tdata  <= drv_item.data;
            s_tlast  <= drv_item.last;
        end
    end

    // monitor: check each output item, stall on a changing pattern
    int        hold_left = 0;
    int        mode_left = 0;
    int        stall_mode = 0;
    int        rx_phase = 0;
    logic      rdy;
    text_out_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_bytes++;
                if (expected_out.size() == 0) begin
                    $display("%0t: unexpected item, expected none, got data %h last %b valid %b",
                             $time, m_tdata, m_tlast, m_tuser);
                    errors++;
                end else begin
                    want = expected_out.pop_front();
                    if (m_tdata !== want.data) begin
                        $display("%0t: out_byte expected %h got %h", $time, want.data, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: out_last expected %b got %b", $time, want.last, m_tlast);
                        errors++;
                    end
                    if (m_tuser !== want.ok) begin
                        $display("%0t: text_valid expected %b got %b", $time, want.ok, m_tuser);
                        errors++;
                    end
                end
            end
            // long hold-offs so the block fills up and stalls its input
            if (hold_left == 0 && ((n_bytes >= 60 && n_holds == 0) ||
                                   (n_bytes >= 250 && n_holds == 1))) begin
                hold_left = 100;
                n_holds++;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 48);
            end else begin
                mode_left--;
            end
            rx_phase++;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (stall_mode)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = (rx_phase % 4 == 0);
                    default: rdy = (rx_phase % 4 != 0);
                endcase
            end
            m_tready <= rdy;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int       kind;
        text_in_t it;
        for (int i = 0; i < N_DIR; i++) begin
            it.data = DIR_BYTES[i];
            it.last = DIR_ENDS[i];
            tx_items.push_back(it);
        end
        while (tx_items.size() < N_ITEMS) begin
            repeat ($urandom_range(1, 8)) begin
                kind = $urandom_range(0, 9);
                if (kind < 7) add_good_char($urandom_range(1, 4));
                else if (kind < 9) add_broken_seq();
                else str_bytes.push_back(8'($urandom_range(1, 255)));
            end
            close_string();
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (tx_items.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_out.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d strings, %0d input items, %0d output bytes checked",
                 n_strings, n_items, n_bytes);
        $display("%0d replacement characters predicted, %0d long receiver hold-offs",
                 n_repl, n_holds);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
